[src/sps_pkg.sv]
// Shared constants, types and the arctangent table for the spectrum phase shift block.
package sps_pkg;

    // Default sizing handed to the top level
    localparam int MAX_LOG2_SIZE_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF  = 24;

    // Register file layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int LOG2_W     = 5;
    localparam int PHASE_W    = 32;
    localparam int GAIN_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LOG2_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;

    localparam logic [LOG2_W-1:0]         LOG2_RESET  = 5'd10;
    localparam logic signed [PHASE_W-1:0] PHASE_RESET = 32'sd0;
    localparam logic signed [GAIN_W-1:0]  GAIN_RESET  = 24'sd65536;

    // Rotator
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int GUARD_BITS   = 6;
    localparam int ATAN_W       = 30;
    localparam int INVK_W       = 25;
    // 1/K in Q24, kept positive in a signed field
    localparam logic signed [INVK_W-1:0] INVK = 25'sd10188014;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_in;
        logic              mul;
        logic              setup;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              comp;
        logic              scale;
        logic              out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Arctangent of 2^-s in 2^-32 turns
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] s);
        logic [ATAN_W-1:0] v;
        begin
            case (s)
                5'd0:    v = 30'h20000000;
                5'd1:    v = 30'h12e4051d;
                5'd2:    v = 30'h09fb385b;
                5'd3:    v = 30'h051111d4;
                5'd4:    v = 30'h028b0d43;
                5'd5:    v = 30'h0145d7e1;
                5'd6:    v = 30'h00a2f61e;
                5'd7:    v = 30'h00517c55;
                5'd8:    v = 30'h0028be53;
                5'd9:    v = 30'h00145f2e;
                5'd10:   v = 30'h000a2f98;
                5'd11:   v = 30'h000517cc;
                5'd12:   v = 30'h00028be6;
                5'd13:   v = 30'h000145f3;
                5'd14:   v = 30'h0000a2f9;
                5'd15:   v = 30'h0000517c;
                5'd16:   v = 30'h000028be;
                5'd17:   v = 30'h0000145f;
                5'd18:   v = 30'h00000a2f;
                5'd19:   v = 30'h00000517;
                5'd20:   v = 30'h0000028b;
                5'd21:   v = 30'h00000145;
                5'd22:   v = 30'h000000a2;
                5'd23:   v = 30'h00000051;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[src/sps_if.sv]
// Channel interfaces: input bins, result bins and register writes.
interface sps_bin_if #(
    parameter int SW = sps_pkg::SAMPLE_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] bin_re;
    logic signed [SW-1:0] bin_im;

    modport source(output valid, output bin_re, output bin_im, input ready);
    modport sink(input valid, input bin_re, input bin_im, output ready);
endinterface

interface sps_res_if #(
    parameter int SW = sps_pkg::SAMPLE_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] out_re;
    logic signed [SW-1:0] out_im;
    logic                 frame_end;
    logic                 clipped;

    modport source(output valid, output out_re, output out_im, output frame_end,
                   output clipped, input ready);
    modport sink(input valid, input out_re, input out_im, input frame_end,
                 input clipped, output ready);
endinterface

interface sps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sps_pkg::CFG_IDX_W-1:0]       idx;
    logic [sps_pkg::CFG_DATA_W-1:0]      data;

    modport source(output valid, output idx, output data, input ready);
    modport sink(input valid, input idx, input data, output ready);
endinterface

[src/sps_ctrl.sv]
// Sequencer: steps one bin through multiply, setup, rotation, scaling and output.
module sps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sps_pkg::t_dp_status i_status,
    output sps_pkg::t_dp_cmd    o_cmd
);
    import sps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SETUP,
        S_ITER,
        S_COMP,
        S_SCALE,
        S_OUT
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Decode commands from the current state
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.setup    = (r_state == S_SETUP);
        o_cmd.iter     = (r_state == S_ITER);
        o_cmd.step     = r_step;
        o_cmd.comp     = (r_state == S_COMP);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.out_load = (r_state == S_OUT) && i_status.out_free;
    end

    // Advance through the sequence
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_MUL;
            S_MUL:   n_state = S_SETUP;
            S_SETUP: begin
                n_state = S_ITER;
                n_step  = '0;
            end
            S_ITER: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_COMP;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_COMP:  n_state = S_SCALE;
            S_SCALE: n_state = S_OUT;
            S_OUT:   if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

[src/sps_dp.sv]
// Datapath: registers, bin counter, angle multiply, CORDIC rotator, gain and saturation.
module sps_dp #(
    parameter int MAX_LOG2_SIZE = sps_pkg::MAX_LOG2_SIZE_DEF,
    parameter int SAMPLE_WIDTH  = sps_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_bin_re,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_bin_im,
    input  logic                                i_out_ready,
    input  sps_pkg::t_dp_cmd                    i_cmd,
    output sps_pkg::t_dp_status                 o_status,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_re,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_im,
    output logic                                o_frame_end,
    output logic                                o_clipped
);
    import sps_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = MAX_LOG2_SIZE;
    // Rotator width: guard bits, quadrant sign and CORDIC growth
    localparam int XW  = SW + GUARD_BITS + 3;
    localparam int CXW = XW + INVK_W;          // x * 1/K
    localparam int XSW = CXW - 24;             // compensated value
    localparam int GPW = XSW + GAIN_W;         // xs * gain
    localparam int PW  = GPW - 22;             // final before saturation

    localparam logic [LOG2_W-1:0]      MAX_L   = LOG2_W'(MAX_LOG2_SIZE);
    localparam logic [PHASE_W-1:0]     QOFFS   = 32'h2000_0000;
    localparam logic signed [CXW-1:0]  RND_C   = CXW'(1 << 23);
    localparam logic signed [GPW-1:0]  RND_G   = GPW'(1 << 21);
    localparam logic signed [SW-1:0]   SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]   SAT_MIN = {1'b1, {(SW-1){1'b0}}};

    // Configuration registers
    logic [LOG2_W-1:0]         r_log2_size;
    logic signed [PHASE_W-1:0] r_phase_step;
    logic signed [GAIN_W-1:0]  r_gain;

    // Bin counter and frame math
    logic [CW-1:0]    r_cnt;
    logic [LOG2_W-1:0] eff_l;
    logic [CW:0]      n_len;
    logic [CW:0]      half_len;
    logic [CW-1:0]    bin_idx;
    logic signed [CW:0] k_val;
    logic             is_last;

    // Item registers
    logic signed [SW-1:0]      r_re, r_im;
    logic signed [CW:0]        r_k;
    logic                      r_last;
    logic [PHASE_W-1:0]        r_ang;
    logic signed [CW+PHASE_W:0] ang_prod;

    // Rotator
    logic [PHASE_W-1:0]        q_sum;
    logic [1:0]                quad;
    logic signed [XW-1:0]      re_g, im_g;
    logic signed [XW-1:0]      r_x, r_y;
    logic signed [PHASE_W-1:0] r_z;
    logic signed [XW-1:0]      dx, dy;
    logic signed [PHASE_W-1:0] at;

    // Scaling and output
    logic signed [CXW-1:0] r_xc, r_yc;
    logic signed [CXW-1:0] xr, yr;
    logic signed [GPW-1:0] r_xg, r_yg;
    logic signed [GPW-1:0] xgr, ygr;
    logic signed [PW-1:0]  px, py;
    logic                  ovf_x, ovf_y;
    logic signed [SW-1:0]  sat_x, sat_y;
    logic                  r_out_valid;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_size  <= LOG2_RESET;
            r_phase_step <= PHASE_RESET;
            r_gain       <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOG2_SIZE:  r_log2_size  <= i_cfg_data[LOG2_W-1:0];
                REG_PHASE_STEP: r_phase_step <= $signed(i_cfg_data[PHASE_W-1:0]);
                REG_GAIN:       r_gain       <= $signed(i_cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // Clamp the frame size and find the signed bin number
    assign eff_l    = (r_log2_size > MAX_L) ? MAX_L : r_log2_size;
    assign n_len    = (CW+1)'(1) << eff_l;
    assign half_len = n_len >> 1;
    assign bin_idx  = r_cnt & CW'(n_len - 1'b1);
    assign k_val    = ({1'b0, bin_idx} < half_len) ? $signed({1'b0, bin_idx})
                                                   : $signed({1'b0, bin_idx} - n_len);
    assign is_last  = ({1'b0, bin_idx} == (n_len - 1'b1));

    // Bin counter: wrap after the last bin of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load_in) begin
            r_cnt <= is_last ? '0 : bin_idx + 1'b1;
        end
    end

    // Angle: minus k times the phase step, modulo one turn
    assign ang_prod = r_k * r_phase_step;

    // Quadrant and residual
    assign q_sum = r_ang + QOFFS;
    assign quad  = q_sum[PHASE_W-1:PHASE_W-2];
    assign re_g  = XW'(r_re) <<< GUARD_BITS;
    assign im_g  = XW'(r_im) <<< GUARD_BITS;

    // One CORDIC micro-rotation
    assign dx = r_y >>> i_cmd.step;
    assign dy = r_x >>> i_cmd.step;
    assign at = $signed({2'b00, atan_lut(i_cmd.step)});

    // Rounding of the compensated and scaled values
    assign xr  = r_xc + RND_C;
    assign yr  = r_yc + RND_C;
    assign xgr = r_xg + RND_G;
    assign ygr = r_yg + RND_G;
    assign px  = xgr[GPW-1:22];
    assign py  = ygr[GPW-1:22];

    // Saturate to the sample width
    assign ovf_x = (px[PW-1:SW-1] != {(PW-SW+1){px[SW-1]}});
    assign ovf_y = (py[PW-1:SW-1] != {(PW-SW+1){py[SW-1]}});
    assign sat_x = ovf_x ? (px[PW-1] ? SAT_MIN : SAT_MAX) : px[SW-1:0];
    assign sat_y = ovf_y ? (py[PW-1] ? SAT_MIN : SAT_MAX) : py[SW-1:0];

    // Working registers of one bin
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_re   <= i_bin_re;
            r_im   <= i_bin_im;
            r_k    <= k_val;
            r_last <= is_last;
        end
        if (i_cmd.mul) begin
            r_ang <= PHASE_W'(0) - ang_prod[PHASE_W-1:0];
        end
        if (i_cmd.setup) begin
            r_z <= $signed(r_ang - {quad, {(PHASE_W-2){1'b0}}});
            unique case (quad)
                2'd0: begin r_x <= re_g;  r_y <= im_g;  end
                2'd1: begin r_x <= -im_g; r_y <= re_g;  end
                2'd2: begin r_x <= -re_g; r_y <= -im_g; end
                2'd3: begin r_x <= im_g;  r_y <= -re_g; end
                default: begin r_x <= re_g; r_y <= im_g; end
            endcase
        end
        if (i_cmd.iter) begin
            if (!r_z[PHASE_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.comp) begin
            r_xc <= r_x * INVK;
            r_yc <= r_y * INVK;
        end
        if (i_cmd.scale) begin
            r_xg <= $signed(xr[CXW-1:24]) * r_gain;
            r_yg <= $signed(yr[CXW-1:24]) * r_gain;
        end
    end

    // Output register: load a finished bin, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_re    <= sat_x;
            o_out_im    <= sat_y;
            o_frame_end <= r_last;
            o_clipped   <= ovf_x || ovf_y;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

[src/spectrum_phase_shift_gain.sv]
// Top level: time shift by phase ramp and gain over the bins of one spectrum.
// Each request runs through angle multiply, quadrant setup, 24 CORDIC steps on one shared
// rotator, 1/K compensation, gain multiply and the output register.
// The rotator iterates on one bin at a time: a new request is taken only once the last bin has been loaded for output.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) restarts the frame and restores register defaults.
module spectrum_phase_shift_gain #(
    parameter int MAX_LOG2_SIZE = sps_pkg::MAX_LOG2_SIZE_DEF,
    parameter int SAMPLE_WIDTH  = sps_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sps_cfg_if.sink   i_cfg,
    sps_bin_if.sink   i_bin,
    sps_res_if.source o_res
);
    import sps_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_bin.ready = in_ready;

    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_bin.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sps_dp #(
        .MAX_LOG2_SIZE (MAX_LOG2_SIZE),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.idx),
        .i_cfg_data  (i_cfg.data),
        .i_bin_re    (i_bin.bin_re),
        .i_bin_im    (i_bin.bin_im),
        .i_out_ready (o_res.ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_res.valid),
        .o_out_re    (o_res.out_re),
        .o_out_im    (o_res.out_im),
        .o_frame_end (o_res.frame_end),
        .o_clipped   (o_res.clipped)
    );

    // One bin in flight: no request right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_bin.valid && i_bin.ready) |=> !i_bin.ready)
        else $error("request accepted while a bin is in flight");

    // A loaded result shows up on the output
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_res.valid)
        else $error("loaded result not presented");

    // Rotator step stays inside the arctangent table
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.iter |-> (cmd.step < STEP_W'(CORDIC_STEPS)))
        else $error("rotator step out of range");

endmodule
